>>> hw/rtl/subarray_occurrence_finder_defines.svh
// Assertion macros for the checker file.
`ifndef SUBARRAY_OCCURRENCE_FINDER_DEFINES_SVH
`define SUBARRAY_OCCURRENCE_FINDER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SOF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SOF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define SOF_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/sof_pkg.sv
package sof_pkg;

  localparam int MaxPattern = 16;
  localparam int WordW      = 32;
  localparam int LenW       = $clog2(MaxPattern + 1);

endpackage

>>> hw/rtl/subarray_occurrence_finder.sv
// A text word that completes an occurrence passes the check stage, then the output register.
// One word per cycle unless stalled; the compare cells check all pattern positions at once.
// The input stalls only while a finished check waits behind an occupied output register.
// Reset (rst, synchronous) empties the pattern and clears text position and match count.
// Text window contents are not cleared; they are read only once overwritten by new text.
module subarray_occurrence_finder
  import sof_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic signed [31:0] value,
  input  logic               first,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        start_index,
  output logic [31:0]        match_count
);

  localparam logic [WordW-1:0] WordMax = '1;

  logic [LenW-1:0]   pat_len;
  logic [WordW-1:0]  text_pos;
  logic [WordW-1:0]  found_cnt;

  logic              chk_v;
  logic              chk_ok;
  logic              chk_first;
  logic [WordW-1:0]  chk_start;

  logic              acc;
  logic              load_pat;
  logic              shift_txt;
  logic              pat_full;
  logic [WordW-1:0]  cur;
  logic              chk_ok_next;
  logic [WordW-1:0]  start_next;
  logic              chk_go;
  logic              all_hit;
  logic              hitm;
  logic [WordW-1:0]  base_cnt;
  logic [WordW-1:0]  cnt_next;

  logic [WordW-1:0]      txt_chain [MaxPattern+1];
  logic [WordW-1:0]      pat_chain [MaxPattern+1];
  logic [MaxPattern:0]   pv_chain;
  logic [MaxPattern-1:0] hits;

  assign acc       = in_valid && in_ready;
  assign pat_full  = (pat_len == LenW'(MaxPattern));
  assign load_pat  = acc && !mode && (first || !pat_full);
  assign shift_txt = acc && mode;

  assign cur         = first ? '0 : text_pos;
  assign chk_ok_next = (pat_len != '0) &&
                       (({1'b0, cur} + 33'd1) >= {{(WordW + 1 - LenW){1'b0}}, pat_len});
  assign start_next  = cur + 32'd1 - {{(WordW - LenW){1'b0}}, pat_len};

  assign chk_go   = chk_v && (!out_valid || out_ready);
  assign in_ready = !chk_v || chk_go;

  // Newest text word and newest pattern word both enter at cell 0, so cell i
  // always pairs window word (length - 1 - i) with pattern word (length - 1 - i).
  assign txt_chain[0] = value;
  assign pat_chain[0] = value;
  assign pv_chain[0]  = 1'b1;

  for (genvar i = 0; i < MaxPattern; i++) begin : g_cell
    logic pv_link;

    // A pattern restart drops every older word from the valid chain.
    assign pv_link = (i == 0) ? pv_chain[0] : (pv_chain[i] && !first);

    sof_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift_txt (shift_txt),
      .txt_in    (txt_chain[i]),
      .txt_out   (txt_chain[i+1]),
      .load_pat  (load_pat),
      .pat_in    (pat_chain[i]),
      .pv_in     (pv_link),
      .pat_out   (pat_chain[i+1]),
      .pv_out    (pv_chain[i+1]),
      .hit       (hits[i])
    );
  end

  assign all_hit  = &hits;
  assign hitm     = chk_ok && all_hit;
  assign base_cnt = chk_first ? '0 : found_cnt;
  assign cnt_next = !hitm ? base_cnt : ((base_cnt == WordMax) ? base_cnt : base_cnt + 32'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len   <= '0;
      text_pos  <= '0;
      found_cnt <= '0;
      chk_v     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc && !mode) begin
        if (first) begin
          pat_len <= LenW'(1);
        end else if (!pat_full) begin
          pat_len <= pat_len + LenW'(1);
        end
      end
      if (shift_txt) begin
        text_pos <= (cur == WordMax) ? cur : cur + 32'd1;
      end
      if (chk_go) begin
        found_cnt <= cnt_next;
      end
      if (shift_txt) begin
        chk_v <= 1'b1;
      end else if (chk_go) begin
        chk_v <= 1'b0;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (chk_go && hitm) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift_txt) begin
      chk_ok    <= chk_ok_next;
      chk_first <= first;
      chk_start <= start_next;
    end
    if (chk_go && hitm) begin
      start_index <= chk_start;
      match_count <= cnt_next;
    end
  end

endmodule

>>> hw/rtl/sof_cell.sv
module sof_cell
  import sof_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             shift_txt,
  input  logic [WordW-1:0] txt_in,
  output logic [WordW-1:0] txt_out,
  input  logic             load_pat,
  input  logic [WordW-1:0] pat_in,
  input  logic             pv_in,
  output logic [WordW-1:0] pat_out,
  output logic             pv_out,
  output logic             hit
);

  logic [WordW-1:0] txt;
  logic [WordW-1:0] pat;
  logic             pv;

  always_ff @(posedge clk) begin
    if (shift_txt) begin
      txt <= txt_in;
    end
    if (load_pat) begin
      pat <= pat_in;
    end
  end

  // The valid bit marks cells that hold a word of the current pattern.
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (load_pat) begin
      pv <= pv_in;
    end
  end

  assign txt_out = txt;
  assign pat_out = pat;
  assign pv_out  = pv;
  assign hit     = !pv || (txt == pat);

endmodule

>>> hw/rtl/sof_checker.sv
`include "subarray_occurrence_finder_defines.svh"

module sof_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] start_index,
  input logic [31:0] match_count
);

  // The input side is held back only while a result sits in the output register.
  `SOF_ASSERT_NOW(a_stall_needs_full_out, clk, rst, !in_ready, out_valid && !out_ready, "input stalled without a waiting result")

  // Every reported occurrence counts itself.
  `SOF_ASSERT_NOW(a_count_nonzero, clk, rst, out_valid, match_count != 32'd0, "result with zero match count")

  // A result that is not taken holds its value until the transfer.
  `SOF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(start_index) && $stable(match_count), "result changed while stalled")

  // Nothing is reported in the cycle after reset.
  `SOF_ASSERT_ALWAYS_NEXT(a_reset_quiet, clk, rst, !out_valid, "result present right after reset")

endmodule

bind subarray_occurrence_finder sof_checker u_sof_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .start_index (start_index),
  .match_count (match_count)
);
